### src/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg: shared types, constants and helpers for the HLS color shader
// Channel and hue number formats, pipeline codes and the divider step.
// ----------------------------------------------------------------------------
package hcs_pkg;

  // Channel values are unsigned fractions of full scale.
  localparam int unsigned ChanBits = 16;
  localparam logic [15:0] FULL_SCALE = 16'hFFFF;

  // Hue is held in degrees with 8 fraction bits.
  localparam logic [16:0] DEG_60  = 17'd15360;
  localparam logic [16:0] DEG_120 = 17'd30720;
  localparam logic [16:0] DEG_180 = 17'd46080;
  localparam logic [16:0] DEG_240 = 17'd61440;
  localparam logic [16:0] DEG_360 = 17'd92160;

  // Which channel holds the maximum (ties go to red, then to green).
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // Part of the hue circle that an offset hue falls in.
  localparam logic [1:0] RGN_RISE = 2'd0;
  localparam logic [1:0] RGN_HIGH = 2'd1;
  localparam logic [1:0] RGN_FALL = 2'd2;
  localparam logic [1:0] RGN_LOW  = 2'd3;

  // One output color.
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } pix_t;

  // Fields that ride along with an item through the divider.
  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] light;
    logic        gray;
    logic [1:0]  sel;
    logic        neg;
  } side_t;

  // One lane of the restoring divider: partial remainder, low dividend
  // bits still to be shifted in, divisor and quotient built so far.
  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] lo;
    logic [16:0] dvs;
    logic [15:0] quo;
  } div_lane_t;

  // One restoring division step that resolves quotient bit k.
  function automatic div_lane_t div_step(div_lane_t x, logic [3:0] k);
    logic [17:0] t;
    div_lane_t   y;
    y = x;
    t = {x.rem, x.lo[k]};
    if (t >= {1'b0, x.dvs}) begin
      y.rem    = 17'(t - {1'b0, x.dvs});
      y.quo[k] = 1'b1;
    end else begin
      y.rem    = t[16:0];
      y.quo[k] = 1'b0;
    end
    return y;
  endfunction

endpackage

### src/hls_color_shade.sv
// ----------------------------------------------------------------------------
// hls_color_shade: shades an RGBA color through the HLS color space
// Lightness and saturation are scaled by a programmable gain and clamped.
// ----------------------------------------------------------------------------
// Usage:
// An input item (red_in, green_in, blue_in, alpha_in) is taken at a rising
// edge where in_valid is high and in_stall is low. A result item appears on
// red_out, green_out, blue_out, alpha_out with out_valid and is taken at an
// edge where out_stall is low. Alpha is copied through untouched.
// The gain is written on the cfg channel (cfg_valid, cfg_ready, cfg_data,
// 8 fraction bits, 256 is unity); cfg_ready is always high. Write it only
// while no item is in flight.
// Throughput is one item per clock while the skid register is empty. Items
// pass through the 16 stages of the bit-serial divider for saturation and
// hue, plus the multiply and correction stages around it.
// Reset clears all valid bits and loads the gain with 256.
// When the receiver stalls, one more item lands in a skid register and then
// in_stall rises; the whole pipeline holds until the skid register drains.
// ----------------------------------------------------------------------------
module hls_color_shade (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] red_in,
  input  logic [15:0] green_in,
  input  logic [15:0] blue_in,
  input  logic [15:0] alpha_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out,
  output logic [15:0] alpha_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);
  import hcs_pkg::*;

  localparam int unsigned DivSteps = 16;

  logic [9:0] shade;
  logic       en;
  logic       skid_valid;
  pix_t       skid;
  pix_t       out_pix;

  // Gain register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      shade <= 10'd256;
    end else if (cfg_valid) begin
      shade <= cfg_data;
    end
  end

  // The pipeline advances whenever the skid register is empty.
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // Stage A: input registers.
  logic        a_valid;
  logic [15:0] a_r, a_g, a_b, a_a;

  // Stage B: max, min and hue difference.
  logic        b_valid;
  logic [15:0] b_mx, b_mn, b_mag, b_a;
  logic [1:0]  b_sel;
  logic        b_neg;
  logic [1:0]  sel_n;
  logic [15:0] mx_n, mn_n, mag_n;
  logic [16:0] diff_n;

  always_comb begin
    if (a_r >= a_g && a_r >= a_b) begin
      sel_n = SEL_RED;
    end else if (a_g >= a_b) begin
      sel_n = SEL_GREEN;
    end else begin
      sel_n = SEL_BLUE;
    end
    unique case (sel_n)
      SEL_RED: begin
        mx_n   = a_r;
        diff_n = {1'b0, a_g} - {1'b0, a_b};
      end
      SEL_GREEN: begin
        mx_n   = a_g;
        diff_n = {1'b0, a_b} - {1'b0, a_r};
      end
      default: begin
        mx_n   = a_b;
        diff_n = {1'b0, a_r} - {1'b0, a_g};
      end
    endcase
    mn_n = a_r;
    if (a_g < mn_n) mn_n = a_g;
    if (a_b < mn_n) mn_n = a_b;
    mag_n = diff_n[16] ? 16'(~diff_n + 17'd1) : diff_n[15:0];
  end

  // Stage C (divider entry): sums, divisors and dividends.
  logic        dv_valid [DivSteps+1];
  side_t       dv_side  [DivSteps+1];
  div_lane_t   dv_s     [DivSteps+1];
  div_lane_t   dv_h     [DivSteps+1];
  logic [16:0] sum_n, sdvs_n;
  logic [15:0] d_n;
  logic [31:0] snum_n, hnum_n;
  side_t       side_n;
  div_lane_t   ls_n, lh_n;

  always_comb begin
    sum_n  = {1'b0, b_mx} + {1'b0, b_mn};
    d_n    = b_mx - b_mn;
    sdvs_n = (sum_n <= {1'b0, FULL_SCALE}) ? sum_n : 17'h1FFFE - sum_n;
    snum_n = {d_n, 16'h0000} - {16'h0000, d_n};
    hnum_n = {2'b00, b_mag, 14'h0000} - {6'b000000, b_mag, 10'h000};
    side_n.alpha = b_a;
    side_n.light = sum_n[16:1];
    side_n.gray  = (d_n == 16'h0000);
    side_n.sel   = b_sel;
    side_n.neg   = b_neg;
    ls_n.rem = {1'b0, snum_n[31:16]};
    ls_n.lo  = snum_n[15:0];
    ls_n.dvs = sdvs_n;
    ls_n.quo = 16'h0000;
    lh_n.rem = {1'b0, hnum_n[31:16]};
    lh_n.lo  = hnum_n[15:0];
    lh_n.dvs = {1'b0, d_n};
    lh_n.quo = 16'h0000;
  end

  // Divider stages: one quotient bit of each lane per stage, MSB first.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam logic [3:0] BitIx = 4'(DivSteps - 1 - k);
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (en) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_side[k+1] <= dv_side[k];
        dv_s[k+1]    <= div_step(dv_s[k], BitIx);
        dv_h[k+1]    <= div_step(dv_h[k], BitIx);
      end
    end
  end

  // Stage E: hue assembly and gain products.
  logic        e_valid, e_gray;
  logic [16:0] e_h;
  logic [25:0] e_lp, e_sp;
  logic [15:0] e_a;
  side_t       fin;
  logic [15:0] s_eff, hm;
  logic [16:0] base_n;
  logic [17:0] hsum_n;
  logic [16:0] h_n;

  always_comb begin
    fin   = dv_side[DivSteps];
    hm    = dv_h[DivSteps].quo;
    s_eff = fin.gray ? 16'h0000 : dv_s[DivSteps].quo;
    unique case (fin.sel)
      SEL_RED:   base_n = 17'd0;
      SEL_GREEN: base_n = DEG_120;
      default:   base_n = DEG_240;
    endcase
    hsum_n = fin.neg ? {1'b0, base_n} - {2'b00, hm} : {1'b0, base_n} + {2'b00, hm};
    h_n    = hsum_n[17] ? 17'(hsum_n + {1'b0, DEG_360}) : hsum_n[16:0];
    if (fin.gray) h_n = 17'd0;
  end

  // Stage F: clamp the shaded values and form the three offset hues.
  logic        f_valid, f_gray;
  logic [15:0] f_l, f_s, f_a;
  logic [16:0] f_x [3];
  logic [15:0] lq_n, sq_n;
  logic [16:0] xr_n, xb_n;

  always_comb begin
    lq_n = (e_lp[25:24] != 2'b00) ? FULL_SCALE : e_lp[23:8];
    sq_n = (e_sp[25:24] != 2'b00) ? FULL_SCALE : e_sp[23:8];
    xr_n = e_h + DEG_120;
    if (xr_n >= DEG_360) xr_n = xr_n - DEG_360;
    xb_n = (e_h < DEG_120) ? e_h + DEG_240 : e_h - DEG_120;
  end

  // Stage G: product for the upper HLS bound.
  logic        g_valid, g_gray, g_hi;
  logic [15:0] g_l, g_s, g_a;
  logic [16:0] g_x [3];
  logic [32:0] g_prod;
  logic [16:0] mb_n;

  assign mb_n = f_l[15] ? {1'b0, f_s} : {1'b0, FULL_SCALE} + {1'b0, f_s};

  // Stage H: quotient estimate of the product over full scale.
  logic        h_valid, h_gray, h_hi;
  logic [15:0] h_l, h_s, h_a;
  logic [16:0] h_x [3];
  logic [17:0] h_q, h_r;
  logic [33:0] qt_n, qfs_n, r34_n;

  always_comb begin
    qt_n  = {1'b0, g_prod} + {17'h00000, g_prod[32:16]};
    qfs_n = {qt_n[33:16], 16'h0000} - {16'h0000, qt_n[33:16]};
    r34_n = {1'b0, g_prod} - qfs_n;
  end

  // Stage I: correct the quotient and settle the upper bound m2.
  logic        i_valid, i_gray;
  logic [15:0] i_l, i_a, i_m2;
  logic [16:0] i_x [3];
  logic [17:0] qc_n, m2raw_n;

  always_comb begin
    if (h_r >= 18'h1FFFE) begin
      qc_n = h_q + 18'd2;
    end else if (h_r >= {2'b00, FULL_SCALE}) begin
      qc_n = h_q + 18'd1;
    end else begin
      qc_n = h_q;
    end
    m2raw_n = h_hi ? {2'b00, h_l} + {2'b00, h_s} - qc_n : qc_n;
  end

  // Stage J: lower bound m1, ramp height and hue regions.
  logic        j_valid, j_gray;
  logic [15:0] j_l, j_a, j_m1, j_m2, j_dm;
  logic [1:0]  j_rgn [3];
  logic [13:0] j_t   [3];
  logic [17:0] m1raw_n;
  logic [15:0] m1c_n, m1_n;
  logic [1:0]  rgn_n [3];
  logic [13:0] t_n   [3];

  always_comb begin
    m1raw_n = {1'b0, i_l, 1'b0} - {2'b00, i_m2};
    if (m1raw_n[17]) begin
      m1c_n = 16'h0000;
    end else if (m1raw_n[16]) begin
      m1c_n = FULL_SCALE;
    end else begin
      m1c_n = m1raw_n[15:0];
    end
    m1_n = (m1c_n > i_m2) ? i_m2 : m1c_n;
    for (int c = 0; c < 3; c++) begin
      if (i_x[c] < DEG_60) begin
        rgn_n[c] = RGN_RISE;
        t_n[c]   = i_x[c][13:0];
      end else if (i_x[c] < DEG_180) begin
        rgn_n[c] = RGN_HIGH;
        t_n[c]   = 14'd0;
      end else if (i_x[c] < DEG_240) begin
        rgn_n[c] = RGN_FALL;
        t_n[c]   = 14'(DEG_240 - i_x[c]);
      end else begin
        rgn_n[c] = RGN_LOW;
        t_n[c]   = 14'd0;
      end
    end
  end

  // Stage K: ramp products.
  logic        k_valid, k_gray;
  logic [15:0] k_l, k_a, k_m1, k_m2;
  logic [1:0]  k_rgn [3];
  logic [29:0] k_pk  [3];

  // Stage L: divide by 60 degrees as a shift and a reciprocal of 15.
  logic        l_valid, l_gray;
  logic [15:0] l_l, l_a, l_m1, l_m2;
  logic [1:0]  l_rgn [3];
  logic [19:0] l_y   [3];
  logic [16:0] l_qe  [3];
  logic [32:0] recip_n [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      recip_n[c] = {13'h0000, k_pk[c][29:10]} * {20'h00000, 13'd4369};
    end
  end

  // Stage M: correct the ramp quotient and pick each channel.
  logic        m_valid;
  pix_t        m_pix;
  pix_t        pix_n;
  logic [20:0] fifteen_n [3];
  logic [20:0] rr_n      [3];
  logic [16:0] qf_n      [3];
  logic [15:0] ch_n      [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fifteen_n[c] = {l_qe[c], 4'h0} - {4'h0, l_qe[c]};
      rr_n[c]      = {1'b0, l_y[c]} - fifteen_n[c];
      if (rr_n[c] >= 21'd45) begin
        qf_n[c] = l_qe[c] + 17'd3;
      end else if (rr_n[c] >= 21'd30) begin
        qf_n[c] = l_qe[c] + 17'd2;
      end else if (rr_n[c] >= 21'd15) begin
        qf_n[c] = l_qe[c] + 17'd1;
      end else begin
        qf_n[c] = l_qe[c];
      end
      unique case (l_rgn[c]) inside
        RGN_RISE, RGN_FALL: ch_n[c] = 16'({1'b0, l_m1} + qf_n[c]);
        RGN_HIGH:           ch_n[c] = l_m2;
        default:            ch_n[c] = l_m1;
      endcase
      if (l_gray) ch_n[c] = l_l;
    end
    pix_n.red   = ch_n[0];
    pix_n.green = ch_n[1];
    pix_n.blue  = ch_n[2];
    pix_n.alpha = l_a;
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      dv_valid[0] <= 1'b0;
      e_valid     <= 1'b0;
      f_valid     <= 1'b0;
      g_valid     <= 1'b0;
      h_valid     <= 1'b0;
      i_valid     <= 1'b0;
      j_valid     <= 1'b0;
      k_valid     <= 1'b0;
      l_valid     <= 1'b0;
      m_valid     <= 1'b0;
    end else if (en) begin
      a_valid     <= in_valid;
      b_valid     <= a_valid;
      dv_valid[0] <= b_valid;
      e_valid     <= dv_valid[DivSteps];
      f_valid     <= e_valid;
      g_valid     <= f_valid;
      h_valid     <= g_valid;
      i_valid     <= h_valid;
      j_valid     <= i_valid;
      k_valid     <= j_valid;
      l_valid     <= k_valid;
      m_valid     <= l_valid;
    end
  end

  // Payload registers of the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= red_in;
      a_g <= green_in;
      a_b <= blue_in;
      a_a <= alpha_in;

      b_mx  <= mx_n;
      b_mn  <= mn_n;
      b_mag <= mag_n;
      b_sel <= sel_n;
      b_neg <= diff_n[16];
      b_a   <= a_a;

      dv_side[0] <= side_n;
      dv_s[0]    <= ls_n;
      dv_h[0]    <= lh_n;

      e_h    <= h_n;
      e_lp   <= {10'h000, fin.light} * {16'h0000, shade};
      e_sp   <= {10'h000, s_eff} * {16'h0000, shade};
      e_a    <= fin.alpha;
      e_gray <= fin.gray;

      f_l    <= lq_n;
      f_s    <= sq_n;
      f_gray <= e_gray || (sq_n == 16'h0000);
      f_a    <= e_a;
      f_x[0] <= xr_n;
      f_x[1] <= e_h;
      f_x[2] <= xb_n;

      g_prod <= {17'h00000, f_l} * {16'h0000, mb_n};
      g_hi   <= f_l[15];
      g_l    <= f_l;
      g_s    <= f_s;
      g_a    <= f_a;
      g_gray <= f_gray;
      g_x    <= f_x;

      h_q    <= qt_n[33:16];
      h_r    <= r34_n[17:0];
      h_hi   <= g_hi;
      h_l    <= g_l;
      h_s    <= g_s;
      h_a    <= g_a;
      h_gray <= g_gray;
      h_x    <= g_x;

      i_m2   <= (m2raw_n > {2'b00, FULL_SCALE}) ? FULL_SCALE : m2raw_n[15:0];
      i_l    <= h_l;
      i_a    <= h_a;
      i_gray <= h_gray;
      i_x    <= h_x;

      j_m1   <= m1_n;
      j_m2   <= i_m2;
      j_dm   <= i_m2 - m1_n;
      j_rgn  <= rgn_n;
      j_t    <= t_n;
      j_l    <= i_l;
      j_a    <= i_a;
      j_gray <= i_gray;

      for (int c = 0; c < 3; c++) begin
        k_pk[c] <= {14'h0000, j_dm} * {16'h0000, j_t[c]};
      end
      k_rgn  <= j_rgn;
      k_m1   <= j_m1;
      k_m2   <= j_m2;
      k_l    <= j_l;
      k_a    <= j_a;
      k_gray <= j_gray;

      for (int c = 0; c < 3; c++) begin
        l_y[c]  <= k_pk[c][29:10];
        l_qe[c] <= recip_n[c][32:16];
      end
      l_rgn  <= k_rgn;
      l_m1   <= k_m1;
      l_m2   <= k_m2;
      l_l    <= k_l;
      l_a    <= k_a;
      l_gray <= k_gray;

      m_pix <= pix_n;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= m_valid;
      end
    end else if (m_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_pix <= skid_valid ? skid : m_pix;
    end else if (!skid_valid) begin
      skid <= m_pix;
    end
  end

  assign red_out   = out_pix.red;
  assign green_out = out_pix.green;
  assign blue_out  = out_pix.blue;
  assign alpha_out = out_pix.alpha;

  // The skid register only holds an item while the output is occupied.
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register is empty");

  // The skid register only fills behind a stalled output.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid register filled without a stalled output");

  // An item leaving the pipeline into a stalled output is caught.
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (m_valid && en && out_valid && out_stall) |=> skid_valid)
    else $error("item dropped at the output");

  // The saturation divider ends with a remainder below its divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_valid[DivSteps] && !dv_side[DivSteps].gray)
      |-> (dv_s[DivSteps].rem < dv_s[DivSteps].dvs))
    else $error("divider remainder not below divisor");

  // The HLS bounds stay ordered.
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    j_valid |-> (j_m1 <= j_m2))
    else $error("lower bound above upper bound");

endmodule

### tb/hls_color_shade_test.sv
// ----------------------------------------------------------------------------
// hls_color_shade_test: self-checking testbench for the HLS color shader
// Drives RGBA items through the shader under several gain settings and
// idling mixes, predicts each shaded color and compares it field by field.
// ----------------------------------------------------------------------------
module hls_color_shade_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } color_t;

  localparam longint Fs = 65535;
  localparam longint Deg60 = 60 * 256;
  localparam longint Deg360 = 360 * 256;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] alpha_in;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] alpha_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [9:0]  cfg_data;

  color_t pending_colors[$];
  color_t shaded_colors[$];
  logic [9:0] gain;
  logic in_held;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int errors;

  hls_color_shade i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .alpha_out(alpha_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // One channel from the offset hue on the m1..m2 ramp.
  function automatic longint hue_channel(longint hue, longint m1, longint m2);
    longint x;
    x = hue;
    if (x >= Deg360) x -= Deg360;
    if (x < 0) x += Deg360;
    if (x < Deg60) return m1 + ((m2 - m1) * x) / Deg60;
    if (x < 3 * Deg60) return m2;
    if (x < 4 * Deg60) return m1 + ((m2 - m1) * (4 * Deg60 - x)) / Deg60;
    return m1;
  endfunction

  function automatic longint clamp_fs(longint v);
    if (v < 0) return 0;
    if (v > Fs) return Fs;
    return v;
  endfunction

  // Shaded color for one input color under the current gain.
  function automatic color_t predict_shade(color_t c);
    longint r, g, b, mx, mn, sum, d, l, s, h, m1, m2;
    color_t o;
    r = c.red;
    g = c.green;
    b = c.blue;
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    sum = mx + mn;
    l = sum / 2;
    s = 0;
    h = 0;
    if (mx != mn) begin
      d = mx - mn;
      if (sum <= Fs) s = (d * Fs) / sum;
      else s = (d * Fs) / (2 * Fs - sum);
      if (r == mx) h = (Deg60 * (g - b)) / d;
      else if (g == mx) h = 2 * Deg60 + (Deg60 * (b - r)) / d;
      else h = 4 * Deg60 + (Deg60 * (r - g)) / d;
      if (h < 0) h += Deg360;
    end
    l = clamp_fs((l * gain) >>> 8);
    s = clamp_fs((s * gain) >>> 8);
    o.alpha = c.alpha;
    if (s == 0) begin
      o.red = l[15:0];
      o.green = l[15:0];
      o.blue = l[15:0];
    end else begin
      if (2 * l <= Fs) m2 = (l * (Fs + s)) / Fs;
      else m2 = l + s - (l * s) / Fs;
      m2 = clamp_fs(m2);
      m1 = clamp_fs(2 * l - m2);
      if (m1 > m2) m1 = m2;
      o.red = 16'(clamp_fs(hue_channel(h + 2 * Deg60, m1, m2)));
      o.green = 16'(clamp_fs(hue_channel(h, m1, m2)));
      o.blue = 16'(clamp_fs(hue_channel(h - 2 * Deg60, m1, m2)));
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Marks an item that was on the port but not taken at the last edge.
  always @(posedge clk) begin
    in_held <= in_valid && in_stall;
  end

  // Driver: presents queued items, holding each until it is accepted.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_held) begin
      // A stalled item stays on the port.
    end else if (pending_colors.size() > 0 &&
                 $urandom_range(99, 0) >= send_idle_pct) begin
      color_t c;
      c = pending_colors.pop_front();
      in_valid <= 1'b1;
      red_in <= c.red;
      green_in <= c.green;
      blue_in <= c.blue;
      alpha_in <= c.alpha;
      shaded_colors.push_back(predict_shade(c));
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (shaded_colors.size() == 0) begin
        $display("result with no item outstanding");
        errors++;
      end else begin
        color_t w;
        w = shaded_colors.pop_front();
        if (red_out !== w.red) report_mismatch("red", red_out, w.red);
        if (green_out !== w.green) report_mismatch("green", green_out, w.green);
        if (blue_out !== w.blue) report_mismatch("blue", blue_out, w.blue);
        if (alpha_out !== w.alpha) report_mismatch("alpha", alpha_out, w.alpha);
      end
    end
  end

  task automatic queue_color(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             logic [15:0] a);
    color_t c;
    c = '{red: r, green: g, blue: b, alpha: a};
    pending_colors.push_back(c);
  endtask

  // Waits until every queued item has been shaded and checked.
  task automatic drain();
    while (pending_colors.size() > 0 || shaded_colors.size() > 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_gain(logic [9:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gain = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(int count);
    int i;
    int unsigned kind;
    logic [15:0] base;
    for (i = 0; i < count; i++) begin
      kind = $urandom_range(7, 0);
      base = 16'($urandom);
      case (kind)
        0: queue_color(base, base, base, 16'($urandom));
        1: queue_color(base, base, 16'($urandom), 16'($urandom));
        2: queue_color(16'($urandom_range(1, 0) * 16'hFFFF), 16'($urandom),
                       16'($urandom_range(1, 0) * 16'hFFFF), 16'($urandom));
        3: queue_color(base, 16'(base + $urandom_range(3, 0)), 16'($urandom),
                       16'($urandom));
        default: queue_color(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
      endcase
    end
  endtask

  // Stimulus: directed colors, then random phases under varied gains.
  initial begin
    logic [9:0] gains[6];
    int p;
    gains = '{10'd256, 10'd0, 10'd1023, 10'd128, 10'd300, 10'd700};
    errors = 0;
    gain = 10'd256;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes, primaries, secondaries, grays and ties.
    queue_color(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_color(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_color(16'hFFFF, 16'h0000, 16'h0000, 16'h1234);
    queue_color(16'h0000, 16'hFFFF, 16'h0000, 16'hA5A5);
    queue_color(16'h0000, 16'h0000, 16'hFFFF, 16'h5A5A);
    queue_color(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001);
    queue_color(16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000);
    queue_color(16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF);
    queue_color(16'h8000, 16'h8000, 16'h8000, 16'hFFFE);
    queue_color(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000);
    queue_color(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    queue_color(16'hFFFF, 16'hFFFE, 16'hFFFE, 16'h0000);
    queue_color(16'h4000, 16'hC000, 16'h2000, 16'h0000);
    queue_color(16'h1000, 16'h2000, 16'hF000, 16'h0000);
    queue_color(16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
    drain();

    // Random phases, each with its own gain and one of four idling mixes.
    for (p = 0; p < 6; p++) begin
      write_gain(gains[p]);
      queue_color(16'hFFFF, 16'h0000, 16'h8000, 16'h0000);
      queue_color(16'h3000, 16'h3000, 16'h3000, 16'hFFFF);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 81; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 81; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      queue_random(250);
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #3ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
src/hcs_pkg.sv
src/hls_color_shade.sv
tb/hls_color_shade_test.sv
